// ----- hdl/pptu_pkg.sv -----
// Shared types and constants for the point projective transform unit.
// No dependencies.
package pptu_pkg;
  localparam int unsigned NUM_PAIRS = 8;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned CFG_AW = 6;
  localparam logic [63:0] PAIR_RST [NUM_PAIRS] = '{
    64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'h0001_0000_0000_0000};
  // Status that travels with each item down the pipeline.
  typedef struct packed {
    logic w_zero;
    logic sat;
  } flags_t;
endpackage

// ----- hdl/point_projective_transform_unit.sv -----
// Point projective transform unit: 4x4 matrix times point, perspective divide.
// Depends on pptu_pkg.
//
//  channel | ports                        | handshake
//  in      | in_x_in, in_y_in, in_z_in    | in_valid / in_ready
//  out     | out_x_out .. out_saturated   | out_valid / out_ready
//  cfg     | psel/penable/pwrite/paddr    | APB, pready tied high
//
// One item per cycle while not stalled. Stages: one of products,
// one of row sums, one of magnitudes, one restoring-division stage per
// quotient bit (QBITS = 33), then one for sign and saturation.
// Reset loads the identity matrix and empties the pipeline.
// A stall freezes every stage at once; in_ready is out_ready || !out_valid.
module point_projective_transform_unit
  import pptu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  input  logic signed [31:0] in_z_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [31:0] out_z_out,
  output logic               out_w_zero,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  // product: 64 bits signed; sum of four: 66 bits
  localparam int unsigned SW = 66;
  localparam int unsigned NW = SW - 1 + FRAC_BITS; // shifted magnitude width
  localparam int unsigned DW = SW;                 // divisor magnitude width
  localparam int unsigned QBITS = 33;              // enough to detect saturation
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NSTG = QBITS + 4;

  logic [63:0] pair_r [NUM_PAIRS];
  logic [2:0]  cfg_idx;
  assign cfg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAIRS; i++) pair_r[i] <= PAIR_RST[i];
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      pair_r[cfg_idx] <= pwdata;
    end
  end
  assign prdata = (paddr[2:0] == 3'd0) ? pair_r[cfg_idx] : 64'd0;

  function automatic logic signed [COEF_W-1:0] elem(input logic [63:0] p [NUM_PAIRS],
                                                    input int k);
    return (k % 2 == 1) ? p[k/2][63:32] : p[k/2][31:0];
  endfunction

  logic adv;
  logic [NSTG-1:0] vld_r;
  assign adv = out_ready || !out_valid;
  assign in_ready = adv;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NSTG-2:0], in_valid};
  end

  // stage 1: products
  logic signed [63:0] prod_r [4][4];
  logic signed [63:0] tr_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= elem(pair_r, r) * in_x_in;
        prod_r[r][1] <= elem(pair_r, 4 + r) * in_y_in;
        prod_r[r][2] <= elem(pair_r, 8 + r) * in_z_in;
        tr_r[r] <= 64'(elem(pair_r, 12 + r)) <<< FRAC_BITS;
      end
    end
  end

  // stage 2: row sums
  logic signed [SW-1:0] sum_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++)
        sum_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2])
                    + SW'(tr_r[r]);
    end
  end

  // stage 3: magnitudes and signs
  logic [NW-1:0] num_mag [3];
  logic [DW-1:0] den_mag;
  logic [2:0]    neg_s [QBITS+1];
  flags_t        fl_s [QBITS+1];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      num_mag[r] = NW'(sum_r[r][SW-1] ? -sum_r[r] : sum_r[r]) << FRAC_BITS;
    end
    den_mag = sum_r[3][SW-1] ? DW'(-sum_r[3]) : DW'(sum_r[3]);
  end

  // division pipeline: per stage, remainder, remaining dividend, quotient
  logic [RW-1:0]    rem_s [QBITS+1][3];
  logic [NW-1:0]    dvd_s [QBITS+1][3];
  logic [QBITS-1:0] quo_s [QBITS+1][3];
  logic             ovf_s [QBITS+1][3];
  logic [DW-1:0]    dv_s [QBITS+1];

  // pre-load: the top NW-QBITS dividend bits form a quotient that must be
  // zero; compare them once against the divisor to flag overflow
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        rem_s[0][r] <= RW'(num_mag[r] >> QBITS);
        dvd_s[0][r] <= num_mag[r] << (NW - QBITS);
        quo_s[0][r] <= '0;
        ovf_s[0][r] <= RW'(num_mag[r] >> QBITS) >= RW'(den_mag);
        neg_s[0][r] <= sum_r[r][SW-1] ^ sum_r[3][SW-1];
      end
      dv_s[0] <= den_mag;
      fl_s[0].w_zero <= (sum_r[3] == '0);
      fl_s[0].sat <= 1'b0;
    end
  end

  for (genvar g = 0; g < QBITS; g++) begin : g_div
    logic [RW-1:0] trial [3];
    logic [RW-1:0] diff [3];
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        trial[r] = {rem_s[g][r][RW-2:0], dvd_s[g][r][NW-1]};
        diff[r] = trial[r] - RW'(dv_s[g]);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int r = 0; r < 3; r++) begin
          if (trial[r] >= RW'(dv_s[g])) begin
            rem_s[g+1][r] <= diff[r];
            quo_s[g+1][r] <= {quo_s[g][r][QBITS-2:0], 1'b1};
          end else begin
            rem_s[g+1][r] <= trial[r];
            quo_s[g+1][r] <= {quo_s[g][r][QBITS-2:0], 1'b0};
          end
          dvd_s[g+1][r] <= dvd_s[g][r] << 1;
          ovf_s[g+1][r] <= ovf_s[g][r];
        end
        neg_s[g+1] <= neg_s[g];
        dv_s[g+1] <= dv_s[g];
        fl_s[g+1] <= fl_s[g];
      end
    end
  end

  // final stage: sign, clip, zero-divisor override
  logic signed [31:0] res [3];
  logic [2:0] clip;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (neg_s[QBITS][r]) begin
        clip[r] = ovf_s[QBITS][r] || quo_s[QBITS][r] > QBITS'(33'h0_8000_0000);
        res[r] = clip[r] ? 32'sh8000_0000 : -quo_s[QBITS][r][31:0];
      end else begin
        clip[r] = ovf_s[QBITS][r] || quo_s[QBITS][r] > QBITS'(33'h0_7FFF_FFFF);
        res[r] = clip[r] ? 32'sh7FFF_FFFF : quo_s[QBITS][r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_out <= fl_s[QBITS].w_zero ? '0 : res[0];
      out_y_out <= fl_s[QBITS].w_zero ? '0 : res[1];
      out_z_out <= fl_s[QBITS].w_zero ? '0 : res[2];
      out_w_zero <= fl_s[QBITS].w_zero;
      out_saturated <= !fl_s[QBITS].w_zero && (|clip);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_out))
    else $error("output item changed under stall");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_w_zero && out_saturated))
    else $error("w_zero and saturated both set");
  a_wzero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_x_out == 0 && out_y_out == 0 && out_z_out == 0)
    else $error("zero divisor item not zeroed");
endmodule
